[rtl/core/client_dedup_ack_table_macros.svh]
// Assertion macros used by the table's RTL.
`ifndef CLIENT_DEDUP_ACK_TABLE_MACROS_SVH
`define CLIENT_DEDUP_ACK_TABLE_MACROS_SVH

`define CDAT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define CDAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/cdat_pkg.sv]
`timescale 1ns / 1ps
package cdat_pkg;

  localparam int unsigned DEF_CLIENT_SLOTS  = 256;
  localparam int unsigned DEF_HISTORY_DEPTH = 20;

  localparam int unsigned IP_W      = 32;
  localparam int unsigned PORT_W    = 16;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned INDEX_W   = 32;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned TIMEOUT_W = 16;

  localparam logic [LEN_W-1:0]     MIN_LENGTH    = 16'd32;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd30;

  localparam logic CMD_DATAGRAM = 1'b0;
  localparam logic CMD_TICK     = 1'b1;

endpackage

[rtl/core/cdat_if.sv]
`timescale 1ns / 1ps
interface cdat_req_if;
  import cdat_pkg::*;

  logic               valid;
  logic               ready;
  logic               command;
  logic [IP_W-1:0]    src_ip;
  logic [PORT_W-1:0]  src_port;
  logic [LEN_W-1:0]   datagram_length;
  logic [INDEX_W-1:0] msg_index;
  logic               payload_is_stop;

  modport source (output valid, command, src_ip, src_port, datagram_length, msg_index,
                  payload_is_stop, input ready);
  modport sink (input valid, command, src_ip, src_port, datagram_length, msg_index,
                payload_is_stop, output ready);
endinterface

interface cdat_ack_if;
  import cdat_pkg::*;

  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] ack_index;
  logic               last_of_run;
  logic               stop_request;

  modport source (output valid, ack_index, last_of_run, stop_request, input ready);
  modport sink (input valid, ack_index, last_of_run, stop_request, output ready);
endinterface

[rtl/core/cdat_ram.sv]
`timescale 1ns / 1ps
module cdat_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/client_dedup_ack_table.sv]
`timescale 1ns / 1ps
// Per-client acknowledgement table. Client slots live in a slot RAM and the
// index histories in a history RAM, both with one read port; the busy flags
// of the slots are flip-flops cleared by reset, so no clearing pass follows
// reset. One request is worked on at a time and a new request is taken only
// when the previous one is finished. A tick runs the idle sweep through the
// slot RAM. A datagram goes through the slot lookup, the history search
// (when a slot is found), the update, and a history read and an output
// step per acknowledgement word, the output step waiting while the output
// is stalled; a datagram shorter than 32 bytes gets no acknowledgement.
module client_dedup_ack_table #(
  parameter int unsigned CLIENT_SLOTS  = cdat_pkg::DEF_CLIENT_SLOTS,
  parameter int unsigned HISTORY_DEPTH = cdat_pkg::DEF_HISTORY_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  cdat_req_if.sink                          in_if,
  cdat_ack_if.source                        out_if,
  input  logic                              cfg_we_i,
  input  logic [cdat_pkg::TIMEOUT_W-1:0]    cfg_wdata_i
);
  import cdat_pkg::*;
  `include "client_dedup_ack_table_macros.svh"

  localparam int unsigned SW  = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
  localparam int unsigned PW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned HD  = CLIENT_SLOTS * HISTORY_DEPTH;
  localparam int unsigned HAW = (HD > 1) ? $clog2(HD) : 1;
  localparam int unsigned SLW = IP_W + PORT_W + TIME_W + CW + PW;

  typedef enum logic [2:0] {
    S_IDLE, S_SWEEP, S_LOOK, S_HSRCH, S_UPD, S_EMRD, S_EMOUT
  } state_e;

  state_e                state_q;
  logic [TIME_W-1:0]     seconds_q;
  logic [TIMEOUT_W-1:0]  timeout_q;
  logic [CLIENT_SLOTS-1:0] valid_q;
  logic [IP_W-1:0]       ip_q;
  logic [PORT_W-1:0]     port_q;
  logic [INDEX_W-1:0]    idx_q;
  logic                  stop_in_q;
  logic                  stop_q;
  logic                  seen_q;
  logic [SW:0]           scan_q;
  logic                  rd_pend_q;
  logic [SW-1:0]         rd_idx_q;
  logic                  free_fnd_q;
  logic [SW-1:0]         free_idx_q;
  logic [SW-1:0]         slot_q;
  logic [CW-1:0]         cnt_q;
  logic [PW-1:0]         wp_q;
  logic [CW-1:0]         hscan_q;
  logic                  hpend_q;
  logic [CW-1:0]         em_left_q;
  logic [PW-1:0]         em_pos_q;
  logic                  out_valid_q;
  logic [INDEX_W-1:0]    out_index_q;
  logic                  out_last_q;
  logic                  out_stop_q;

  logic                  slot_re;
  logic                  slot_we;
  logic [SLW-1:0]        slot_wdata;
  logic [SLW-1:0]        slot_rdata;
  logic [IP_W-1:0]       rd_ip;
  logic [PORT_W-1:0]     rd_port;
  logic [TIME_W-1:0]     rd_last;
  logic [CW-1:0]         rd_cnt;
  logic [PW-1:0]         rd_wp;
  logic                  hist_re;
  logic                  hist_we;
  logic [HAW-1:0]        hist_base;
  logic [HAW-1:0]        hist_raddr;
  logic [HAW-1:0]        hist_waddr;
  logic [INDEX_W-1:0]    hist_rdata;
  logic [CW-1:0]         cnt_new;
  logic [PW-1:0]         wp_new;
  logic                  out_free;
  logic                  scan_more;
  logic                  hit;
  logic                  aged;

  assign rd_ip   = slot_rdata[SLW-1 -: IP_W];
  assign rd_port = slot_rdata[SLW-IP_W-1 -: PORT_W];
  assign rd_last = slot_rdata[SLW-IP_W-PORT_W-1 -: TIME_W];
  assign rd_cnt  = slot_rdata[PW+CW-1 -: CW];
  assign rd_wp   = slot_rdata[PW-1:0];

  assign scan_more = (scan_q < (SW+1)'(CLIENT_SLOTS));
  assign hit  = valid_q[rd_idx_q] && (rd_ip == ip_q) && (rd_port == port_q);
  assign aged = (seconds_q - rd_last) > {{(TIME_W-TIMEOUT_W){1'b0}}, timeout_q};

  assign slot_re    = ((state_q == S_SWEEP) || (state_q == S_LOOK)) && scan_more;
  assign slot_we    = (state_q == S_UPD);
  assign slot_wdata = {ip_q, port_q, seconds_q, cnt_new, wp_new};

  always_comb begin
    if (seen_q) begin
      cnt_new = cnt_q;
      wp_new  = wp_q;
    end else begin
      cnt_new = (cnt_q < CW'(HISTORY_DEPTH)) ? cnt_q + CW'(1) : cnt_q;
      wp_new  = (wp_q == PW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + PW'(1);
    end
  end

  assign hist_base  = HAW'(slot_q) * HAW'(HISTORY_DEPTH);
  assign hist_we    = (state_q == S_UPD) && !seen_q;
  assign hist_waddr = hist_base + HAW'(wp_q);
  assign hist_re    = ((state_q == S_HSRCH) && (hscan_q < cnt_q)) || (state_q == S_EMRD);
  assign hist_raddr = (state_q == S_EMRD) ? hist_base + HAW'(em_pos_q)
                                          : hist_base + HAW'(hscan_q[PW-1:0]);

  assign out_free = !out_valid_q || out_if.ready;

  cdat_ram #(.WIDTH(SLW), .DEPTH(CLIENT_SLOTS), .AW(SW)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_q),
    .wdata_i (slot_wdata),
    .re_i    (slot_re),
    .raddr_i (scan_q[SW-1:0]),
    .rdata_o (slot_rdata)
  );

  cdat_ram #(.WIDTH(INDEX_W), .DEPTH(HD), .AW(HAW)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (idx_q),
    .re_i    (hist_re),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seconds_q   <= '0;
      timeout_q   <= TIMEOUT_RESET;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      rd_pend_q   <= 1'b0;
      hpend_q     <= 1'b0;
      free_fnd_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_if.ready && (state_q != S_EMOUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_if.valid) begin
            ip_q       <= in_if.src_ip;
            port_q     <= in_if.src_port;
            idx_q      <= in_if.msg_index;
            stop_in_q  <= in_if.payload_is_stop;
            scan_q     <= '0;
            rd_pend_q  <= 1'b0;
            free_fnd_q <= 1'b0;
            if (in_if.command == CMD_TICK) begin
              seconds_q <= seconds_q + TIME_W'(1);
              state_q   <= S_SWEEP;
            end else if (in_if.datagram_length >= MIN_LENGTH) begin
              state_q <= S_LOOK;
            end
          end
        end
        S_SWEEP: begin
          rd_pend_q <= scan_more;
          rd_idx_q  <= scan_q[SW-1:0];
          if (scan_more) begin
            scan_q <= scan_q + (SW+1)'(1);
          end
          if (rd_pend_q && aged) begin
            valid_q[rd_idx_q] <= 1'b0;
          end
          if (!scan_more && !rd_pend_q) begin
            state_q <= S_IDLE;
          end
        end
        S_LOOK: begin
          rd_pend_q <= scan_more;
          rd_idx_q  <= scan_q[SW-1:0];
          if (scan_more) begin
            scan_q <= scan_q + (SW+1)'(1);
          end
          hscan_q <= '0;
          hpend_q <= 1'b0;
          seen_q  <= 1'b0;
          if (rd_pend_q && hit) begin
            slot_q  <= rd_idx_q;
            cnt_q   <= rd_cnt;
            wp_q    <= rd_wp;
            state_q <= S_HSRCH;
          end else begin
            if (rd_pend_q && !valid_q[rd_idx_q] && !free_fnd_q) begin
              free_fnd_q <= 1'b1;
              free_idx_q <= rd_idx_q;
            end
            if (!scan_more && !rd_pend_q) begin
              if (free_fnd_q) begin
                slot_q             <= free_idx_q;
                valid_q[free_idx_q] <= 1'b1;
                cnt_q              <= '0;
                wp_q               <= '0;
                state_q            <= S_HSRCH;
              end else begin
                state_q <= S_IDLE;
              end
            end
          end
        end
        S_HSRCH: begin
          hpend_q <= (hscan_q < cnt_q);
          if (hscan_q < cnt_q) begin
            hscan_q <= hscan_q + CW'(1);
          end
          if (hpend_q && (hist_rdata == idx_q)) begin
            seen_q  <= 1'b1;
            state_q <= S_UPD;
          end else if (!(hscan_q < cnt_q) && !hpend_q) begin
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          stop_q    <= !seen_q && stop_in_q;
          em_left_q <= cnt_new;
          em_pos_q  <= (wp_new == '0) ? PW'(HISTORY_DEPTH - 1) : wp_new - PW'(1);
          state_q   <= S_EMRD;
        end
        S_EMRD: begin
          state_q <= S_EMOUT;
        end
        S_EMOUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_index_q <= hist_rdata;
            out_last_q  <= (em_left_q == CW'(1));
            out_stop_q  <= stop_q;
            em_left_q   <= em_left_q - CW'(1);
            em_pos_q    <= (em_pos_q == '0) ? PW'(HISTORY_DEPTH - 1) : em_pos_q - PW'(1);
            state_q     <= (em_left_q == CW'(1)) ? S_IDLE : S_EMRD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_if.ready         = (state_q == S_IDLE);
  assign out_if.valid        = out_valid_q;
  assign out_if.ack_index    = out_index_q;
  assign out_if.last_of_run  = out_last_q;
  assign out_if.stop_request = out_stop_q;

  `CDAT_ASSERT_NEXT(a_tick_advances, in_if.valid && in_if.ready && in_if.command == CMD_TICK, seconds_q == $past(seconds_q) + 32'd1, "seconds counter missed a tick")
  `CDAT_ASSERT_NOW(a_run_continues, out_if.valid && out_if.ready && !out_if.last_of_run, state_q == S_EMRD || state_q == S_EMOUT, "acknowledgement run ended early")
  `CDAT_ASSERT_NOW(a_hist_pos_range, hist_we, wp_q <= PW'(HISTORY_DEPTH - 1), "history write beyond depth")
  `CDAT_ASSERT_NOW(a_update_busy_slot, slot_we, valid_q[slot_q], "update of a free slot")

endmodule

[test/cdat_ack_checker.sv]
`timescale 1ns / 1ps
module cdat_ack_checker
  import cdat_pkg::*;
#(
  parameter int unsigned SLOTS = DEF_CLIENT_SLOTS,
  parameter int unsigned DEPTH = DEF_HISTORY_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  cdat_req_if                  req,
  cdat_ack_if                  ack,
  input  logic                 cfg_we_i,
  input  logic [TIMEOUT_W-1:0] cfg_wdata_i,
  output int unsigned          fail_count_o,
  output int unsigned          acks_pending_o,
  output int unsigned          acks_seen_o
);

  typedef struct packed {
    logic [INDEX_W-1:0] ack_index;
    logic               last_of_run;
    logic               stop_request;
  } ack_word_t;

  ack_word_t          ack_queue[$];
  logic               busy[SLOTS];
  logic [IP_W-1:0]    owner_ip[SLOTS];
  logic [PORT_W-1:0]  owner_port[SLOTS];
  logic [TIME_W-1:0]  stamp_sec[SLOTS];
  int unsigned        hist_len[SLOTS];
  logic [INDEX_W-1:0] hist[SLOTS][DEPTH];
  logic [TIME_W-1:0]  seconds;
  logic [TIMEOUT_W-1:0] timeout;

  function automatic void sweep_idle();
    logic [TIME_W-1:0] age;
    seconds = seconds + 1;
    for (int i = 0; i < SLOTS; i++) begin
      age = seconds - stamp_sec[i];
      if (busy[i] && age > {16'd0, timeout}) busy[i] = 1'b0;
    end
  endfunction

  function automatic void predict_acks(logic [IP_W-1:0] ip, logic [PORT_W-1:0] port,
                                       logic [LEN_W-1:0] len, logic [INDEX_W-1:0] idx,
                                       logic stop);
    int s;
    logic is_new;
    logic flag;
    ack_word_t w;
    s = -1;
    is_new = 1'b1;
    flag = 1'b0;
    if (len < MIN_LENGTH) return;
    for (int i = 0; i < SLOTS && s < 0; i++)
      if (busy[i] && owner_ip[i] == ip && owner_port[i] == port) s = i;
    for (int i = 0; i < SLOTS && s < 0; i++)
      if (!busy[i]) begin
        s = i;
        busy[i] = 1'b1;
        owner_ip[i] = ip;
        owner_port[i] = port;
        hist_len[i] = 0;
      end
    if (s < 0) return;
    stamp_sec[s] = seconds;
    for (int i = 0; i < hist_len[s]; i++)
      if (hist[s][i] == idx) is_new = 1'b0;
    if (is_new) begin
      if (hist_len[s] < DEPTH) begin
        hist[s][hist_len[s]] = idx;
        hist_len[s]++;
      end else begin
        for (int i = 0; i < DEPTH - 1; i++) hist[s][i] = hist[s][i+1];
        hist[s][DEPTH-1] = idx;
      end
      flag = stop;
    end
    for (int k = 0; k < hist_len[s]; k++) begin
      w.ack_index    = hist[s][hist_len[s]-1-k];
      w.last_of_run  = (k == hist_len[s] - 1);
      w.stop_request = flag;
      ack_queue.push_back(w);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ack_word_t w;
    int unsigned errs;
    errs = 0;
    if (!rst_ni) begin
      ack_queue.delete();
      for (int i = 0; i < SLOTS; i++) begin
        busy[i] = 1'b0;
        stamp_sec[i] = '0;
        hist_len[i] = 0;
      end
      seconds = '0;
      timeout = TIMEOUT_RESET;
      fail_count_o <= 0;
      acks_seen_o <= 0;
    end else begin
      if (cfg_we_i) timeout = cfg_wdata_i;
      if (ack.valid && ack.ready) begin
        acks_seen_o <= acks_seen_o + 1;
        if (ack_queue.size() == 0) begin
          $error("unexpected ack: ack_index %h", ack.ack_index);
          errs++;
        end else begin
          w = ack_queue.pop_front();
          if (ack.ack_index !== w.ack_index) begin
            $error("ack_index: expected %h, actual %h", w.ack_index, ack.ack_index);
            errs++;
          end
          if (ack.last_of_run !== w.last_of_run) begin
            $error("last_of_run: expected %b, actual %b", w.last_of_run, ack.last_of_run);
            errs++;
          end
          if (ack.stop_request !== w.stop_request) begin
            $error("stop_request: expected %b, actual %b", w.stop_request,
                   ack.stop_request);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
      if (req.valid && req.ready) begin
        if (req.command == CMD_TICK) sweep_idle();
        else predict_acks(req.src_ip, req.src_port, req.datagram_length, req.msg_index,
                          req.payload_is_stop);
      end
    end
  end

  assign acks_pending_o = ack_queue.size();

endmodule

[test/tb_client_dedup_ack_table.sv]
`timescale 1ns / 1ps
module tb_client_dedup_ack_table;
  import cdat_pkg::*;

  localparam int unsigned IDLE_LIMIT = 5000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [TIMEOUT_W-1:0] cfg_wdata;
  int unsigned          fail_count;
  int unsigned          acks_pending;
  int unsigned          acks_seen;
  int unsigned          datagrams_sent;
  int unsigned          ticks_sent;
  int unsigned          quiet_cycles = 0;
  int unsigned          ack_stall = 0;
  bit                   no_gaps;
  logic [IP_W-1:0]      pool_ip[8];
  logic [PORT_W-1:0]    pool_port[8];

  cdat_req_if req_bus ();
  cdat_ack_if ack_bus ();

  client_dedup_ack_table dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (req_bus),
    .out_if     (ack_bus),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  cdat_ack_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req           (req_bus),
    .ack           (ack_bus),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .fail_count_o  (fail_count),
    .acks_pending_o(acks_pending),
    .acks_seen_o   (acks_seen)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  always @(posedge clk_i) begin
    int unsigned stall;
    stall = ack_stall;
    if (ack_bus.valid && ack_bus.ready) stall = no_gaps ? 0 : $urandom_range(0, 8);
    else if (stall > 0) stall--;
    ack_stall <= stall;
    ack_bus.ready <= (stall == 0);
  end

  always @(posedge clk_i) begin
    if ((req_bus.valid && req_bus.ready) || (ack_bus.valid && ack_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send(logic cmd, logic [IP_W-1:0] ip, logic [PORT_W-1:0] port,
                      logic [LEN_W-1:0] len, logic [INDEX_W-1:0] idx, logic stop);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid           <= 1'b1;
    req_bus.command         <= cmd;
    req_bus.src_ip          <= ip;
    req_bus.src_port        <= port;
    req_bus.datagram_length <= len;
    req_bus.msg_index       <= idx;
    req_bus.payload_is_stop <= stop;
    do @(posedge clk_i); while (!req_bus.ready);
    if (cmd == CMD_TICK) ticks_sent++;
    else datagrams_sent++;
  endtask

  task automatic tick();
    send(CMD_TICK, $urandom, PORT_W'($urandom), LEN_W'($urandom), $urandom,
         1'($urandom_range(0, 1)));
  endtask

  task automatic drain();
    req_bus.valid <= 1'b0;
    do @(posedge clk_i); while (acks_pending != 0);
    repeat (DEF_CLIENT_SLOTS + 40) @(posedge clk_i);
  endtask

  task automatic set_timeout(logic [TIMEOUT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_traffic(int unsigned count, int unsigned pool_size,
                                int unsigned tick_pct);
    int unsigned c;
    logic [LEN_W-1:0] len;
    logic [INDEX_W-1:0] idx;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(1, 100) <= tick_pct) begin
        tick();
      end else begin
        c = $urandom_range(0, pool_size - 1);
        len = ($urandom_range(0, 6) == 0) ? LEN_W'($urandom_range(0, 31))
                                          : LEN_W'($urandom_range(32, 65535));
        idx = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 35);
        send(CMD_DATAGRAM, pool_ip[c], pool_port[c], len, idx,
             1'($urandom_range(0, 1)));
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    no_gaps = 1'b0;
    datagrams_sent = 0;
    ticks_sent = 0;
    req_bus.valid = 1'b0;
    req_bus.command = CMD_DATAGRAM;
    req_bus.src_ip = '0;
    req_bus.src_port = '0;
    req_bus.datagram_length = '0;
    req_bus.msg_index = '0;
    req_bus.payload_is_stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      pool_ip[i] = $urandom;
      pool_port[i] = PORT_W'($urandom);
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(CMD_DATAGRAM, 32'h0, 16'h0, 16'd0, 32'h0, 1'b0);
    send(CMD_DATAGRAM, 32'h0, 16'h0, 16'd31, 32'h1, 1'b1);
    send(CMD_DATAGRAM, 32'h0, 16'h0, 16'd32, 32'h0, 1'b0);
    send(CMD_DATAGRAM, 32'h0, 16'h0, 16'd65535, 32'hFFFF_FFFF, 1'b1);
    send(CMD_DATAGRAM, 32'h0, 16'h0, 16'd100, 32'hFFFF_FFFF, 1'b1);
    send(CMD_DATAGRAM, 32'h0, 16'h0, 16'd65507, 32'h0000_0007, 1'b0);
    send(CMD_DATAGRAM, 32'hFFFF_FFFF, 16'hFFFF, 16'd32, 32'hAAAA_5555, 1'b1);
    send(CMD_DATAGRAM, 32'hFFFF_FFFF, 16'h0, 16'd40, 32'h5555_AAAA, 1'b0);
    send(CMD_DATAGRAM, 32'h0, 16'hFFFF, 16'd40, 32'h5555_AAAA, 1'b1);
    tick();
    send(CMD_DATAGRAM, 32'h0, 16'h0, 16'd32, 32'h0, 1'b1);
    tick();
    drain();

    set_timeout(16'd65535);
    random_traffic(74, 4, 10);
    for (int k = 0; k < 262; k++)
      send(CMD_DATAGRAM, 32'hC0A8_0000 + k, PORT_W'($urandom),
           LEN_W'($urandom_range(32, 65535)), $urandom, 1'($urandom_range(0, 1)));
    drain();

    set_timeout(16'd1);
    tick();
    tick();
    random_traffic(70, 6, 30);
    drain();

    set_timeout(16'd0);
    random_traffic(25, 3, 30);
    drain();

    set_timeout(16'd30);
    random_traffic(25, 8, 5);
    drain();

    $display("Sent %0d datagrams and %0d ticks; checked %0d acknowledgements.",
             datagrams_sent, ticks_sent, acks_seen);
    $display("Timeouts 30, 65535, 1 and 0 were used, with a full client table reached.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/cdat_pkg.sv
rtl/core/cdat_if.sv
rtl/core/cdat_ram.sv
rtl/core/client_dedup_ack_table.sv
test/cdat_ack_checker.sv
test/tb_client_dedup_ack_table.sv
